// ===== sv/cpo_pkg.sv =====
// Shared constants, job codes and controller/datapath interface types for
// the closed polyline offset block. Depends on nothing else.
`default_nettype none
package cpo_pkg;

	localparam int DEF_COORD_BITS = 24;
	localparam int DEF_MAX_POINTS = 65536;
	localparam logic [15:0] DEF_WIDTH = 16'd256;

	localparam int IDX_W = 16;
	localparam int NW = 33;
	localparam int NORM_W = 31;
	localparam int Q_W = 17;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = Q_W;

	localparam logic [1:0] JOB_A = 2'd0;
	localparam logic [1:0] JOB_B = 2'd1;
	localparam logic [1:0] JOB_C = 2'd2;

	typedef struct packed {
		logic       cap_in;
		logic       upd_vtx;
		logic       clr_loop;
		logic       ld_job;
		logic [1:0] job;
		logic       norm_step;
		logic       sq_a;
		logic       sq_b;
		logic       sq_sum;
		logic       sqrt_step;
		logic       div_mul;
		logic       div_ld;
		logic       div_step;
		logic       div_b;
		logic       ld_out;
		logic       out_few;
	} cmd_t;

	typedef struct packed {
		logic few_before;
		logic total_lt3;
		logic closes;
		logic u_zero;
		logic norm_done;
		logic sqrt_last;
		logic div_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/closed_polyline_offset.sv =====
// Top level of the closed polyline offset block: stream ports, word packing
// and the controller and datapath. Depends on cpo_pkg, cpo_ctrl, cpo_datapath.
//
// Vertices of a closed loop arrive one word at a time on the slave stream;
// tlast marks the closing vertex. Each vertex from the third on releases the
// offset of the one before; the closing vertex releases its own offset and
// then that of vertex 0, the latter with tlast set on the master stream. A
// loop of one or two vertices gives a single word flagged too few points.
// The configuration register (offset width, Q8.8) is written by cfg_we.
// One offset runs from set-up to the output register through normalising
// shifts, 32 square root steps and two 17-step restoring divisions on one
// shared unit. A degenerate chord skips the arithmetic. One vertex is
// worked on at a time; s_tready is high only while the controller waits
// for a word. The finished word sits in an output register; while the
// receiver stalls, the next offset completes and then waits. Reset clears
// the loop, empties the output and sets the width to 1.0.
`default_nettype none
module closed_polyline_offset #(
	parameter int COORD_BITS = cpo_pkg::DEF_COORD_BITS,
	parameter int MAX_POINTS = cpo_pkg::DEF_MAX_POINTS
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire [15:0]                             cfg_wdata,
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	// point_x, point_z
	input  wire [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,
	input  wire                                    s_tlast,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	// offset_x, offset_z, vertex_index
	output logic [((2*COORD_BITS+16+7)/8)*8-1:0]   m_tdata,
	// degenerate, too_few_points
	output logic [1:0]                             m_tuser,
	output logic                                   m_tlast
);
	import cpo_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int OUT_W = ((2*CB + IDX_W + 7) / 8) * 8;

	cmd_t cmd;
	status_t status;
	logic signed [CB-1:0] ox, oz;
	logic [IDX_W-1:0] oidx;
	logic odeg, ofew;

	cpo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.status(status), .cmd(cmd)
	);

	cpo_datapath #(.COORD_BITS(COORD_BITS), .MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_x(s_tdata[CB-1:0]), .in_z(s_tdata[2*CB-1:CB]), .in_last(s_tlast),
		.out_ready(m_tready), .out_valid(m_tvalid),
		.out_x(ox), .out_z(oz), .out_idx(oidx),
		.out_deg(odeg), .out_few(ofew), .out_fin(m_tlast)
	);

	assign m_tdata = OUT_W'({oidx, oz, ox});
	assign m_tuser = {ofew, odeg};

endmodule
`default_nettype wire

// ===== sv/cpo_datapath.sv =====
// Datapath: vertex history, normalisation, multipliers, square root,
// restoring divider and the output register. Depends on cpo_pkg.
`default_nettype none
module cpo_datapath #(
	parameter int COORD_BITS = 24,
	parameter int MAX_POINTS = 65536
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  cpo_pkg::cmd_t                  cmd,
	output cpo_pkg::status_t               status,
	input  wire                            cfg_we,
	input  wire [15:0]                     cfg_wdata,
	input  wire signed [COORD_BITS-1:0]    in_x,
	input  wire signed [COORD_BITS-1:0]    in_z,
	input  wire                            in_last,
	input  wire                            out_ready,
	output logic                           out_valid,
	output logic signed [COORD_BITS-1:0]   out_x,
	output logic signed [COORD_BITS-1:0]   out_z,
	output logic [cpo_pkg::IDX_W-1:0]      out_idx,
	output logic                           out_deg,
	output logic                           out_few,
	output logic                           out_fin
);
	import cpo_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SW = ((CB > Q_W) ? CB : Q_W) + 2;
	localparam int NUM_W = 50;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	logic [15:0] width_q;
	logic signed [CB-1:0] in_x_q, in_z_q;
	logic in_last_q;
	logic signed [CB-1:0] first_x_q, first_z_q, second_x_q, second_z_q;
	logic signed [CB-1:0] prev_x_q, prev_z_q, cur_x_q, cur_z_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [CB-1:0] c_x_q, c_z_q;
	logic neg_x_q, neg_z_q;
	logic [NW-1:0] a_q, b_q;
	logic [IDX_W-1:0] idx_q;
	logic fin_q;

	logic [2*NORM_W-1:0] p_q, acc_q;
	logic [63:0] s_q;
	logic [31:0] root_q;
	logic [34:0] rem_q;
	logic [34:0] dr_q;
	logic [Q_W-1:0] dq_q, qa_q, qb_q;
	logic [5:0] step_q;

	logic signed [CB-1:0] jc_x, jc_z, jp_x, jp_z, jn_x, jn_z;
	logic [IDX_W-1:0] j_idx;
	logic signed [DW-1:0] ux, uz;
	logic [DW-1:0] abs_x, abs_z;
	logic [NW-1:0] mx;
	logic n_hi, n_lo;
	logic [34:0] rem_t, trial;
	logic [NUM_W-1:0] num;
	logic [34:0] r_t, dvs;
	logic d_ge;
	logic [Q_W-1:0] dq_n;
	logic [NORM_W-1:0] mul_op;
	logic signed [SW-1:0] sum_x, sum_z, qx, qz;
	logic signed [CB-1:0] sat_x, sat_z;

	always_comb begin
		jc_x = cur_x_q; jc_z = cur_z_q;
		jp_x = prev_x_q; jp_z = prev_z_q;
		jn_x = in_x_q; jn_z = in_z_q;
		j_idx = IDX_W'(cnt_q - CNT_W'(1));
		unique case (cmd.job)
			JOB_A: begin
			end
			JOB_B: begin
				jn_x = first_x_q; jn_z = first_z_q;
			end
			JOB_C: begin
				jc_x = first_x_q; jc_z = first_z_q;
				jp_x = cur_x_q; jp_z = cur_z_q;
				jn_x = second_x_q; jn_z = second_z_q;
				j_idx = '0;
			end
			default: begin
			end
		endcase
		ux = DW'(jp_z) - DW'(jn_z);
		uz = DW'(jn_x) - DW'(jp_x);
		abs_x = ux[DW-1] ? (~ux + DW'(1)) : ux;
		abs_z = uz[DW-1] ? (~uz + DW'(1)) : uz;
	end

	assign mx = (a_q > b_q) ? a_q : b_q;
	assign n_hi = (mx[NW-1:NORM_W] != '0);
	assign n_lo = (mx[NW-1:NORM_W-1] == '0);

	assign rem_t = {rem_q[32:0], s_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	assign mul_op = cmd.div_b ? b_q[NORM_W-1:0] : a_q[NORM_W-1:0];
	assign num = NUM_W'({p_q[46:0], 1'b0}) + NUM_W'(root_q);
	assign r_t = {dr_q[33:0], dq_q[Q_W-1]};
	assign dvs = {2'b00, root_q, 1'b0};
	assign d_ge = (r_t >= dvs);
	assign dq_n = {dq_q[Q_W-2:0], d_ge};

	always_comb begin
		qx = SW'($signed({1'b0, qa_q}));
		qz = SW'($signed({1'b0, qb_q}));
		sum_x = SW'(c_x_q) + (neg_x_q ? -qx : qx);
		sum_z = SW'(c_z_q) + (neg_z_q ? -qz : qz);
		if (sum_x > SAT_HI) sat_x = CB'(SAT_HI);
		else if (sum_x < SAT_LO) sat_x = CB'(SAT_LO);
		else sat_x = CB'(sum_x);
		if (sum_z > SAT_HI) sat_z = CB'(SAT_HI);
		else if (sum_z < SAT_LO) sat_z = CB'(SAT_LO);
		else sat_z = CB'(sum_z);
	end

	always_comb begin
		status.few_before = (cnt_q < CNT_W'(2));
		status.total_lt3 = (cnt_q < CNT_W'(3));
		status.closes = in_last_q;
		status.u_zero = (a_q == '0) && (b_q == '0);
		status.norm_done = !n_hi && !n_lo;
		status.sqrt_last = (step_q == 6'(SQRT_STEPS - 1));
		status.div_last = (step_q == 6'(DIV_STEPS - 1));
		status.out_free = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DEF_WIDTH;
			cnt_q <= '0;
			out_valid <= 1'b0;
			first_x_q <= '0; first_z_q <= '0;
			second_x_q <= '0; second_z_q <= '0;
			prev_x_q <= '0; prev_z_q <= '0;
			cur_x_q <= '0; cur_z_q <= '0;
		end else begin
			if (cfg_we) width_q <= cfg_wdata;
			if (cmd.upd_vtx) begin
				if (cnt_q == CNT_W'(0)) begin
					first_x_q <= in_x_q; first_z_q <= in_z_q;
				end
				if (cnt_q == CNT_W'(1)) begin
					second_x_q <= in_x_q; second_z_q <= in_z_q;
				end
				prev_x_q <= cur_x_q; prev_z_q <= cur_z_q;
				cur_x_q <= in_x_q; cur_z_q <= in_z_q;
				if (cnt_q != CNT_MAX) cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.clr_loop) begin
				cnt_q <= '0;
				first_x_q <= '0; first_z_q <= '0;
				second_x_q <= '0; second_z_q <= '0;
				prev_x_q <= '0; prev_z_q <= '0;
				cur_x_q <= '0; cur_z_q <= '0;
			end
			if (cmd.ld_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_x_q <= in_x;
			in_z_q <= in_z;
			in_last_q <= in_last;
		end
		if (cmd.ld_job) begin
			c_x_q <= jc_x; c_z_q <= jc_z;
			neg_x_q <= ux[DW-1]; neg_z_q <= uz[DW-1];
			a_q <= NW'(abs_x); b_q <= NW'(abs_z);
			idx_q <= j_idx;
			fin_q <= (cmd.job == JOB_C);
		end
		if (cmd.norm_step) begin
			if (n_hi) begin
				a_q <= a_q >> 1; b_q <= b_q >> 1;
			end else begin
				a_q <= a_q << 1; b_q <= b_q << 1;
			end
		end
		if (cmd.sq_a) p_q <= a_q[NORM_W-1:0] * a_q[NORM_W-1:0];
		if (cmd.sq_b) begin
			acc_q <= p_q;
			p_q <= b_q[NORM_W-1:0] * b_q[NORM_W-1:0];
		end
		if (cmd.sq_sum) begin
			s_q <= 64'(acc_q) + 64'(p_q);
			root_q <= '0;
			rem_q <= '0;
			step_q <= '0;
		end
		if (cmd.sqrt_step) begin
			s_q <= s_q << 2;
			step_q <= step_q + 6'd1;
			if (rem_t >= trial) begin
				rem_q <= rem_t - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_t;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.div_mul) p_q <= (2*NORM_W)'(width_q * mul_op);
		if (cmd.div_ld) begin
			dr_q <= 35'(num >> Q_W);
			dq_q <= num[Q_W-1:0];
			step_q <= '0;
		end
		if (cmd.div_step) begin
			dr_q <= d_ge ? (r_t - dvs) : r_t;
			dq_q <= dq_n;
			step_q <= step_q + 6'd1;
			if (status.div_last) begin
				if (cmd.div_b) qb_q <= dq_n;
				else qa_q <= dq_n;
			end
		end
		if (cmd.ld_out) begin
			if (cmd.out_few) begin
				out_x <= '0; out_z <= '0; out_idx <= '0;
				out_deg <= 1'b0; out_few <= 1'b1; out_fin <= 1'b1;
			end else if (status.u_zero) begin
				out_x <= c_x_q; out_z <= c_z_q; out_idx <= idx_q;
				out_deg <= 1'b1; out_few <= 1'b0; out_fin <= fin_q;
			end else begin
				out_x <= sat_x; out_z <= sat_z; out_idx <= idx_q;
				out_deg <= 1'b0; out_few <= 1'b0; out_fin <= fin_q;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/cpo_ctrl.sv =====
// Controller state machine: sequences vertex intake, the offset jobs and
// loop closure. Depends on cpo_pkg.
`default_nettype none
module cpo_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  cpo_pkg::status_t  status,
	output cpo_pkg::cmd_t     cmd
);
	import cpo_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_UPD   = 4'd2;
	localparam logic [3:0] ST_CLOSE = 4'd3;
	localparam logic [3:0] ST_FEW   = 4'd4;
	localparam logic [3:0] ST_SETUP = 4'd5;
	localparam logic [3:0] ST_NORM  = 4'd6;
	localparam logic [3:0] ST_SQA   = 4'd7;
	localparam logic [3:0] ST_SQB   = 4'd8;
	localparam logic [3:0] ST_SUM   = 4'd9;
	localparam logic [3:0] ST_SQRT  = 4'd10;
	localparam logic [3:0] ST_DMUL  = 4'd11;
	localparam logic [3:0] ST_DLD   = 4'd12;
	localparam logic [3:0] ST_DSTEP = 4'd13;
	localparam logic [3:0] ST_EMIT  = 4'd14;

	logic [3:0] state_q, state_d;
	logic [1:0] job_q, job_d;
	logic divb_q, divb_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		job_d = job_q;
		divb_d = divb_q;
		cmd = '0;
		cmd.job = job_q;
		cmd.div_b = divb_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (status.few_before) state_d = ST_UPD;
				else begin
					job_d = JOB_A;
					state_d = ST_SETUP;
				end
			end
			ST_UPD: begin
				cmd.upd_vtx = 1'b1;
				state_d = status.closes ? ST_CLOSE : ST_IDLE;
			end
			ST_CLOSE: begin
				if (status.total_lt3) state_d = ST_FEW;
				else begin
					job_d = JOB_B;
					state_d = ST_SETUP;
				end
			end
			ST_FEW: begin
				if (status.out_free) begin
					cmd.ld_out = 1'b1;
					cmd.out_few = 1'b1;
					cmd.clr_loop = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SETUP: begin
				cmd.ld_job = 1'b1;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				if (status.u_zero) state_d = ST_EMIT;
				else if (status.norm_done) state_d = ST_SQA;
				else cmd.norm_step = 1'b1;
			end
			ST_SQA: begin
				cmd.sq_a = 1'b1;
				state_d = ST_SQB;
			end
			ST_SQB: begin
				cmd.sq_b = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sq_sum = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (status.sqrt_last) begin
					divb_d = 1'b0;
					state_d = ST_DMUL;
				end
			end
			ST_DMUL: begin
				cmd.div_mul = 1'b1;
				state_d = ST_DLD;
			end
			ST_DLD: begin
				cmd.div_ld = 1'b1;
				state_d = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					if (!divb_q) begin
						divb_d = 1'b1;
						state_d = ST_DMUL;
					end else state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.ld_out = 1'b1;
					unique case (job_q)
						JOB_A: state_d = ST_UPD;
						JOB_B: begin
							job_d = JOB_C;
							state_d = ST_SETUP;
						end
						default: begin
							cmd.clr_loop = 1'b1;
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= JOB_A;
			divb_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q <= job_d;
			divb_q <= divb_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/cpo_checker.sv =====
// Port-level checks on the closed polyline offset block, bound to the top
// level. Depends only on the top level's ports.
`default_nettype none
module cpo_checker #(
	parameter int COORD_BITS = 24
) (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  m_tvalid,
	input wire                                  m_tready,
	input wire [((2*COORD_BITS+16+7)/8)*8-1:0]  m_tdata,
	input wire [1:0]                            m_tuser,
	input wire                                  m_tlast
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output word dropped");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled word changed");
	a_few_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == '0 && !m_tuser[0])
		else $error("too few points word malformed");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[2*COORD_BITS+15:2*COORD_BITS] == 16'd0)
		else $error("last word not vertex zero");
endmodule

bind closed_polyline_offset cpo_checker #(.COORD_BITS(COORD_BITS)) u_cpo_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
